/* rtl/gift_pkg.sv */
// ----------------------------------------------------------------------------
// GIFT-64-128 package
// Round constants, S-boxes, permutation and key update helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gift_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned KeyW   = 128;
  localparam int unsigned NumRnd = 28;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [KeyW-1:0]   key_t;

  typedef struct packed {
    logic   mode;
    block_t data;
  } item_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] v);
    logic [3:0] r;
    begin
      case (v)
        4'h0: r = 4'h1; 4'h1: r = 4'ha; 4'h2: r = 4'h4; 4'h3: r = 4'hc;
        4'h4: r = 4'h6; 4'h5: r = 4'hf; 4'h6: r = 4'h3; 4'h7: r = 4'h9;
        4'h8: r = 4'h2; 4'h9: r = 4'hd; 4'ha: r = 4'hb; 4'hb: r = 4'h7;
        4'hc: r = 4'h5; 4'hd: r = 4'h0; 4'he: r = 4'h8; default: r = 4'he;
      endcase
      return r;
    end
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] v);
    logic [3:0] r;
    begin
      case (v)
        4'h0: r = 4'hd; 4'h1: r = 4'h0; 4'h2: r = 4'h8; 4'h3: r = 4'h6;
        4'h4: r = 4'h2; 4'h5: r = 4'hc; 4'h6: r = 4'h4; 4'h7: r = 4'hb;
        4'h8: r = 4'he; 4'h9: r = 4'h7; 4'ha: r = 4'h1; 4'hb: r = 4'ha;
        4'hc: r = 4'h3; 4'hd: r = 4'h9; 4'he: r = 4'hf; default: r = 4'h5;
      endcase
      return r;
    end
  endfunction

  function automatic int unsigned perm_pos(input int unsigned i);
    int unsigned q, m, j;
    begin
      q = i / 16;
      m = i % 16;
      j = i % 4;
      return 4 * q + 16 * ((3 * (m / 4) + j) % 4) + j;
    end
  endfunction

  // Round constant for round r (0-based)
  function automatic logic [5:0] rcon(input int unsigned r);
    logic [5:0] c;
    begin
      c = '0;
      for (int unsigned n = 0; n <= r; n++) begin
        c = {c[4:0], ~(c[5] ^ c[4])};
      end
      return c;
    end
  endfunction

  function automatic block_t add_round(input block_t x, input logic [15:0] u,
                                       input logic [15:0] v, input logic [5:0] c);
    block_t y;
    begin
      y = x;
      for (int i = 0; i < 16; i++) begin
        y[4*i]   = y[4*i] ^ v[i];
        y[4*i+1] = y[4*i+1] ^ u[i];
      end
      for (int i = 0; i < 6; i++) begin
        y[4*i+3] = y[4*i+3] ^ c[i];
      end
      y[63] = ~y[63];
      return y;
    end
  endfunction

  // Key update: k7..k0 <- k1>>>2, k0>>>12, k7..k2
  function automatic key_t key_next(input key_t k);
    logic [15:0] k0, k1;
    begin
      k0 = k[15:0];
      k1 = k[31:16];
      return {{k1[1:0], k1[15:2]}, {k0[11:0], k0[15:12]}, k[127:32]};
    end
  endfunction

  // Key state at the start of round r
  function automatic key_t key_at(input key_t k, input int unsigned r);
    key_t t;
    begin
      t = k;
      for (int unsigned n = 0; n < r; n++) begin
        t = key_next(t);
      end
      return t;
    end
  endfunction

endpackage

/* rtl/gift_if.sv */
// ----------------------------------------------------------------------------
// GIFT stream interface
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface gift_if #(
  parameter int unsigned W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gift_round.sv */
// ----------------------------------------------------------------------------
// GIFT round stage
// One registered round, encryption or decryption selected per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gift_round import gift_pkg::*; #(
  parameter int unsigned Rnd = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  item_t  item_i,
  input  key_t   key_i,
  output logic   valid_o,
  output item_t  item_o
);
  // Decrypt uses round NumRnd-1-Rnd
  localparam int unsigned DecRnd = NumRnd - 1 - Rnd;
  localparam logic [5:0] EncC = rcon(Rnd);
  localparam logic [5:0] DecC = rcon(DecRnd);

  key_t   kenc, kdec;
  block_t enc_s, enc_p, dec_a, dec_p, res;
  item_t  item_d, item_q;
  logic   valid_q;

  always_comb begin
    kenc = key_at(key_i, Rnd);
    kdec = key_at(key_i, DecRnd);
    for (int n = 0; n < 16; n++) begin
      enc_s[4*n +: 4] = sbox_fwd(item_i.data[4*n +: 4]);
    end
    for (int unsigned i = 0; i < 64; i++) begin
      enc_p[perm_pos(i)] = enc_s[i];
    end
    dec_a = add_round(item_i.data, kdec[31:16], kdec[15:0], DecC);
    for (int unsigned i = 0; i < 64; i++) begin
      dec_p[i] = dec_a[perm_pos(i)];
    end
    for (int n = 0; n < 16; n++) begin
      dec_p[4*n +: 4] = sbox_inv(dec_p[4*n +: 4]);
    end
    res = item_i.mode ? dec_p : add_round(enc_p, kenc[31:16], kenc[15:0], EncC);
    item_d = '{mode: item_i.mode, data: res};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

/* rtl/gift64_block_cipher.sv */
// GIFT-64-128 block cipher, 28 unrolled round stages.
// Throughput: one block per cycle; the whole pipeline holds when the output stalls.
// Reset: asynchronous active-low; clears stage valids, key registers reset to zero.
// ----------------------------------------------------------------------------
// GIFT-64 top level
// APB key registers and the 28-stage round pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gift64_block_cipher import gift_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  gift_if.sink        in_if,
  gift_if.source      out_if
);
  // Round count comes from the package so every stage agrees on it
  localparam int unsigned ROUNDS = NumRnd;

  localparam logic [3:0] AddrKeyLow  = 4'h0;
  localparam logic [3:0] AddrKeyHigh = 4'h8;

  logic [63:0] key_low_q, key_high_q;
  logic        en;
  logic        valid_s [ROUNDS+1];
  item_t       item_s  [ROUNDS+1];

  assign pready = 1'b1;

  // Write key words on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr)
        AddrKeyLow:  key_low_q  <= pwdata;
        AddrKeyHigh: key_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrKeyLow:  prdata = key_low_q;
      AddrKeyHigh: prdata = key_high_q;
      default:     prdata = '0;
    endcase
  end

  // Advance the pipeline unless the last stage holds an untaken result
  assign en          = !valid_s[ROUNDS] || out_if.ready;
  assign in_if.ready = en;
  assign valid_s[0]  = in_if.valid;
  // Input transaction carries the mode bit above the 64-bit block
  assign item_s[0]   = '{mode: in_if.data[64], data: in_if.data[63:0]};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
    gift_round #(.Rnd(g)) u_rnd (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[g]),
      .item_i  (item_s[g]),
      .key_i   ({key_high_q, key_low_q}),
      .valid_o (valid_s[g+1]),
      .item_o  (item_s[g+1])
    );
  end

  assign out_if.valid = valid_s[ROUNDS];
  assign out_if.data  = item_s[ROUNDS].data;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input blocked with empty output");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> valid_s[1])
    else $error("accepted block lost");
endmodule

/* bench/tb_gift64_block_cipher.sv */
// ----------------------------------------------------------------------------
// GIFT-64-128 block cipher testbench
// Streams blocks in both modes under several keys, with random idling on
// both channels, and checks each result against a behavioural cipher model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_gift64_block_cipher;
  import gift_pkg::*;

  localparam logic [3:0]  ADDR_KEY_LOW  = 4'h0;
  localparam logic [3:0]  ADDR_KEY_HIGH = 4'h8;
  localparam logic        MODE_ENC      = 1'b0;
  localparam logic        MODE_DEC      = 1'b1;
  localparam int unsigned PIPE_LAT      = 28;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  localparam logic [3:0] SBOX_F [16] = '{4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
                                         4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he};
  localparam logic [3:0] SBOX_I [16] = '{4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
                                         4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5};

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [63:0] pwdata, prdata;

  gift_if #(.W(65)) blk_in ();
  gift_if #(.W(64)) blk_out ();

  gift64_block_cipher u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (blk_in),
    .out_if  (blk_out)
  );

  // Mirror of the key registers and the blocks still owed by the pipeline
  logic [63:0] key_lo_q, key_hi_q;
  block_t      owed_blocks[$];
  int unsigned n_fail;
  int unsigned n_cycles;
  bit          no_idle;     // last part of the run: no gaps on either side
  bit          long_hold;   // ask the receiver for one long stall
  int unsigned rx_hold;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Bit b of the state moves to this position under the forward permutation
  function automatic int unsigned perm_dest(input int unsigned b);
    int unsigned grp, off, lane;
    begin
      grp  = b / 16;
      off  = b % 16;
      lane = b % 4;
      return 4 * grp + 16 * ((3 * (off / 4) + lane) % 4) + lane;
    end
  endfunction

  function automatic block_t mix_round(input block_t x, input logic [15:0] u,
                                       input logic [15:0] v, input logic [5:0] c);
    block_t y;
    begin
      y = x;
      for (int i = 0; i < 16; i++) begin
        y[4*i]   ^= v[i];
        y[4*i+1] ^= u[i];
      end
      for (int i = 0; i < 6; i++) y[4*i+3] ^= c[i];
      y[63] = ~y[63];
      return y;
    end
  endfunction

  // Full 28-round encryption or decryption of one block
  function automatic block_t gift_cipher(input logic dec, input block_t blk,
                                         input logic [63:0] klo, input logic [63:0] khi);
    logic [15:0] rk_u [NumRnd];
    logic [15:0] rk_v [NumRnd];
    logic [5:0]  rk_c [NumRnd];
    logic [15:0] kw [8];
    logic [15:0] w0, w1;
    logic [5:0]  c;
    block_t      x, y;
    begin
      for (int j = 0; j < 4; j++) begin
        kw[j]   = klo[16*j +: 16];
        kw[j+4] = khi[16*j +: 16];
      end
      c = '0;
      for (int r = 0; r < NumRnd; r++) begin
        c = {c[4:0], ~(c[5] ^ c[4])};
        rk_u[r] = kw[1];
        rk_v[r] = kw[0];
        rk_c[r] = c;
        w0 = kw[0];
        w1 = kw[1];
        for (int j = 0; j < 6; j++) kw[j] = kw[j+2];
        kw[6] = {w0[11:0], w0[15:12]};
        kw[7] = {w1[1:0], w1[15:2]};
      end
      x = blk;
      if (dec == MODE_ENC) begin
        for (int r = 0; r < NumRnd; r++) begin
          for (int n = 0; n < 16; n++) x[4*n +: 4] = SBOX_F[x[4*n +: 4]];
          y = '0;
          for (int b = 0; b < 64; b++) y[perm_dest(b)] = x[b];
          x = mix_round(y, rk_u[r], rk_v[r], rk_c[r]);
        end
      end else begin
        for (int r = NumRnd - 1; r >= 0; r--) begin
          x = mix_round(x, rk_u[r], rk_v[r], rk_c[r]);
          y = '0;
          for (int b = 0; b < 64; b++) y[b] = x[perm_dest(b)];
          for (int n = 0; n < 16; n++) y[4*n +: 4] = SBOX_I[y[4*n +: 4]];
          x = y;
        end
      end
      return x;
    end
  endfunction

  // Cycle count with a hard stop
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long stall on request, none at the end
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_out.ready <= 1'b0;
      rx_hold       <= 0;
    end else begin
      if (long_hold) begin
        long_hold = 1'b0;
        rx_hold       <= 400;
        blk_out.ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold       <= rx_hold - 1;
        blk_out.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        rx_hold       <= $urandom_range(0, 12);
        blk_out.ready <= 1'b0;
      end else begin
        blk_out.ready <= 1'b1;
      end
    end
  end

  // Check each result transaction; values are settled mid-cycle
  always @(negedge clk_i) begin
    block_t want;
    if (rst_ni && blk_out.valid && blk_out.ready) begin
      if (owed_blocks.size() == 0) begin
        $error("block_out expected none actual %h", blk_out.data);
        n_fail++;
      end else begin
        want = owed_blocks.pop_front();
        if (blk_out.data !== want) begin
          $error("block_out expected %h actual %h", want, blk_out.data);
          n_fail++;
        end
      end
    end
  end

  // Offer one block; return just after the edge at which it was accepted
  task automatic send_block(input logic md, input block_t blk);
    int unsigned gap;
    begin
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        blk_in.valid <= 1'b0;
        gap = $urandom_range(1, 13);
        repeat (gap) @(posedge clk_i);
      end
      blk_in.valid <= 1'b1;
      blk_in.data  <= {md, blk};
      do @(negedge clk_i); while (!blk_in.ready);
      @(posedge clk_i);
      owed_blocks.push_back(gift_cipher(md, blk, key_lo_q, key_hi_q));
    end
  endtask

  task automatic stop_sending();
    blk_in.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until every result is back, then let the pipeline settle
  task automatic drain();
    begin
      stop_sending();
      while (owed_blocks.size() != 0) @(posedge clk_i);
      repeat (PIPE_LAT + 8) @(posedge clk_i);
    end
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] val);
    begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= val;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_KEY_LOW) key_lo_q = val;
      else key_hi_q = val;
      @(posedge clk_i);
    end
  endtask

  task automatic program_key(input logic [63:0] lo, input logic [63:0] hi);
    begin
      drain();
      apb_write(ADDR_KEY_LOW, lo);
      apb_write(ADDR_KEY_HIGH, hi);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Field extremes and patterns in both modes, zero key first
  task automatic test_directed_blocks();
    block_t pats [6];
    begin
      pats = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa,
               64'h5555_5555_5555_5555, 64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0001};
      foreach (pats[i]) begin
        send_block(MODE_ENC, pats[i]);
        send_block(MODE_DEC, pats[i]);
      end
    end
  endtask

  // Extreme and fixed-pattern keys, each with a short mixed stream
  task automatic test_key_settings();
    begin
      program_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      send_block(MODE_ENC, 64'h0);
      send_block(MODE_DEC, 64'hffff_ffff_ffff_ffff);
      program_key(64'h0, 64'hffff_ffff_ffff_ffff);
      send_block(MODE_ENC, 64'hffff_ffff_ffff_ffff);
      send_block(MODE_DEC, 64'h0);
      program_key(64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100);
      send_block(MODE_ENC, 64'hfedc_ba98_7654_3210);
      send_block(MODE_DEC, 64'hfedc_ba98_7654_3210);
    end
  endtask

  // Random blocks and modes across several random keys
  task automatic test_random_stream();
    begin
      for (int k = 0; k < 6; k++) begin
        program_key(rand64(), rand64());
        for (int i = 0; i < 90; i++) send_block(logic'($urandom_range(0, 1)), rand64());
      end
    end
  endtask

  // Long receiver stall while the sender keeps offering: the pipeline fills
  task automatic test_backpressure();
    begin
      long_hold = 1'b1;
      for (int i = 0; i < 80; i++) send_block(logic'($urandom_range(0, 1)), rand64());
    end
  endtask

  // Sender pauses until all results are back, then a burst with no idling
  task automatic test_pause_and_burst();
    begin
      drain();
      no_idle = 1'b1;
      for (int i = 0; i < 80; i++) send_block(logic'($urandom_range(0, 1)), rand64());
    end
  endtask

  initial begin
    n_fail       = 0;
    n_cycles     = 0;
    no_idle      = 1'b0;
    long_hold    = 1'b0;
    key_lo_q     = '0;
    key_hi_q     = '0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    blk_in.valid = 1'b0;
    blk_in.data  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_blocks();
    test_key_settings();
    test_random_stream();
    test_backpressure();
    test_pause_and_burst();

    drain();
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gift_pkg.sv
rtl/gift_if.sv
rtl/gift_round.sv
rtl/gift64_block_cipher.sv
bench/tb_gift64_block_cipher.sv
